>>> src/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// shared types and constants of the bitmap allocator
// ----------------------------------------------------------------------------
package bma_pkg;

	// field widths
	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 15;
	localparam int COUNT_W  = 16;
	localparam int FOUND_W  = 15;
	localparam int LIMIT_W  = 16;
	localparam int BYTE_BITS = 8;

	// config port
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_BIT_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 16'h8000;

	// value written into a byte taken by the free-byte search
	localparam logic [BYTE_BITS-1:0] BYTE_FIRST = 8'h01;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FREE_BIT  = 3'd0,
		ACT_FREE_RUN  = 3'd1,
		ACT_SET_BIT   = 3'd2,
		ACT_TEST_BIT  = 3'd3,
		ACT_FIND_BYTE = 3'd4,
		ACT_FIND_BIT  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} state_t;

	// per-byte evaluation result
	typedef struct packed {
		logic [BYTE_BITS-1:0] new_byte;
		logic                 wr_en;
		logic                 hit;
		logic [2:0]           hit_bit;
		logic                 any_free;
		logic                 more;
	} eval_t;

endpackage

>>> src/bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_allocator_core
// allocation bitmap with bit, run and search actions over a byte memory
// ----------------------------------------------------------------------------
// The bitmap (clear bit = free) sits in one byte-wide synchronous memory of
// ceil(NUM_BITS/8) entries. After reset a clearing pass writes every byte to
// zero, one byte per cycle; no input transfer is taken meanwhile, config
// writes are. Items are handled one at a time: each visited byte is first
// read from memory, then evaluated and written back. An item that visits no
// byte (unknown action, empty run, search starting at or past the limit)
// goes straight to its result. Run frees and searches walk the bytes one
// after another, so their cost grows with the number of bytes walked. A
// search stops at min(bit_limit, NUM_BITS).
// The result is held in an output register until its transfer completes.
// ----------------------------------------------------------------------------
module bitmap_allocator_core #(
	parameter int NUM_BITS = 32768
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bma_pkg::ADDR_W-1:0]        paddr,
	input  logic [bma_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bma_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bma_pkg::ACTION_W-1:0]      action,
	input  logic [bma_pkg::INDEX_W-1:0]       bit_pos,
	input  logic [bma_pkg::COUNT_W-1:0]       bit_count,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              is_free,
	output logic [bma_pkg::FOUND_W-1:0]       found_index,
	output logic                              status
);

	localparam int DEPTH  = (NUM_BITS + 7) / 8;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// bit positions: wide enough for NUM_BITS rounded up and for start + count
	localparam int POS_W  = ($clog2(NUM_BITS + 8) > 17) ? $clog2(NUM_BITS + 8) : 17;
	localparam int BYTE_W = POS_W - 3;
	localparam logic [POS_W-1:0] NUM_BITS_P = POS_W'(NUM_BITS);
	localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);

	// control state
	bma_pkg::state_t state_q, state_d;
	logic [AW-1:0]   clr_q;
	logic [bma_pkg::LIMIT_W-1:0] bit_limit_q;

	// item registers
	bma_pkg::action_t       act_q;
	logic [POS_W-1:0]       lo_q;
	logic [POS_W-1:0]       hi_q;
	logic [BYTE_W-1:0]      byte_q;
	logic                   is_free_q;
	logic [bma_pkg::FOUND_W-1:0] found_q;
	logic                   status_q;

	// memory port signals
	logic                   mem_rd_en;
	logic [AW-1:0]          mem_rd_addr;
	logic [bma_pkg::BYTE_BITS-1:0] mem_rd_data;
	logic                   mem_wr_en;
	logic [AW-1:0]          mem_wr_addr;
	logic [bma_pkg::BYTE_BITS-1:0] mem_wr_data;

	bma_pkg::eval_t         ev;
	logic [POS_W-1:0]       base;

	// setup of a new item
	bma_pkg::action_t       in_act;
	logic                   in_fire;
	logic                   cfg_wr;
	logic [POS_W-1:0]       idx_w;
	logic [POS_W-1:0]       run_end;
	logic [POS_W-1:0]       run_hi;
	logic [POS_W-1:0]       lim_w;
	logic [POS_W-1:0]       byte_start;
	logic [POS_W-1:0]       round_sum;
	logic [POS_W-1:0]       set_lo;
	logic [POS_W-1:0]       set_hi;
	logic                   set_go;
	logic                   set_fail;

	// ------------------------------------------------------------------------
	// config register: bit_limit at word 0, written on the access phase
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[bma_pkg::ADDR_W-1:2] == bma_pkg::REG_BIT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_limit_q <= bma_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			bit_limit_q <= pwdata[bma_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[bma_pkg::ADDR_W-1:2] == bma_pkg::REG_BIT_LIMIT) begin
			prdata = bma_pkg::APB_DATA_W'(bit_limit_q);
		end
	end

	// ------------------------------------------------------------------------
	// item setup: bit window [lo, hi) to walk and whether any byte is visited
	// ------------------------------------------------------------------------
	assign in_fire = in_valid && in_ready;
	assign in_act  = bma_pkg::action_t'(action);
	assign idx_w   = POS_W'(bit_pos);
	assign run_end = idx_w + POS_W'(bit_count);
	// run frees are clipped at the bitmap end
	assign run_hi  = (run_end > NUM_BITS_P) ? NUM_BITS_P : run_end;
	// a limit above the bitmap acts as the bitmap size
	assign lim_w   = (POS_W'(bit_limit_q) > NUM_BITS_P) ? NUM_BITS_P : POS_W'(bit_limit_q);
	// free-byte search starts at the start rounded up to a byte boundary
	assign round_sum  = idx_w + POS_W'(7);
	assign byte_start = {round_sum[POS_W-1:3], 3'b000};

	always_comb begin
		set_lo   = idx_w;
		set_hi   = idx_w + POS_W'(1);
		set_go   = 1'b0;
		set_fail = 1'b0;
		unique case (in_act)
			bma_pkg::ACT_FREE_BIT,
			bma_pkg::ACT_SET_BIT,
			bma_pkg::ACT_TEST_BIT: begin
				// a single bit beyond the bitmap is not touched, test reads as taken
				set_go = idx_w < NUM_BITS_P;
			end
			bma_pkg::ACT_FREE_RUN: begin
				set_hi = run_hi;
				set_go = idx_w < run_hi;
			end
			bma_pkg::ACT_FIND_BYTE: begin
				set_lo   = byte_start;
				set_hi   = lim_w;
				set_go   = byte_start < lim_w;
				set_fail = !(byte_start < lim_w);
			end
			bma_pkg::ACT_FIND_BIT: begin
				set_hi   = lim_w;
				set_go   = idx_w < lim_w;
				set_fail = !(idx_w < lim_w);
			end
			default: begin
				// unknown action: no state change, all-zero result
				set_go = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// byte store and byte evaluation
	// ------------------------------------------------------------------------
	assign base = {byte_q, 3'b000};

	bma_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	bma_eval #(
		.POS_W (POS_W)
	) u_eval (
		.action  (act_q),
		.rd_data (mem_rd_data),
		.base    (base),
		.lo      (lo_q),
		.hi      (hi_q),
		.res     (ev)
	);

	// ------------------------------------------------------------------------
	// sequencer: read a byte, evaluate and write back, then the next byte.
	// the write-back lands before the next read is issued, so no
	// read ever sees a stale byte
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bma_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = bma_pkg::ST_IDLE;
				end
			end
			bma_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = set_go ? bma_pkg::ST_READ : bma_pkg::ST_RESP;
				end
			end
			bma_pkg::ST_READ: begin
				state_d = bma_pkg::ST_EVAL;
			end
			bma_pkg::ST_EVAL: begin
				// stop on a search hit or when the window is used up
				state_d = (ev.hit || !ev.more) ? bma_pkg::ST_RESP : bma_pkg::ST_READ;
			end
			bma_pkg::ST_RESP: begin
				if (out_ready) begin
					state_d = bma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bma_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_rd_addr = byte_q[AW-1:0];
		mem_wr_addr = byte_q[AW-1:0];
		mem_wr_data = ev.new_byte;
		unique case (state_q)
			bma_pkg::ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
				mem_wr_data = '0;
			end
			bma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bma_pkg::ST_READ: begin
				mem_rd_en = 1'b1;
			end
			bma_pkg::ST_EVAL: begin
				mem_wr_en = ev.wr_en;
			end
			bma_pkg::ST_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bma_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bma_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (state_q == bma_pkg::ST_IDLE && in_fire) begin
			act_q     <= in_act;
			lo_q      <= set_lo;
			hi_q      <= set_hi;
			byte_q    <= set_lo[POS_W-1:3];
			is_free_q <= 1'b0;
			found_q   <= '0;
			status_q  <= set_fail;
		end else if (state_q == bma_pkg::ST_EVAL) begin
			byte_q <= byte_q + BYTE_W'(1);
			if (ev.hit) begin
				found_q <= bma_pkg::FOUND_W'(base + POS_W'(ev.hit_bit));
			end
			if (act_q == bma_pkg::ACT_TEST_BIT) begin
				is_free_q <= ev.any_free;
			end
			if ((act_q == bma_pkg::ACT_FIND_BYTE || act_q == bma_pkg::ACT_FIND_BIT)
				&& !ev.hit && !ev.more) begin
				status_q <= 1'b1;
			end
		end
	end

	assign is_free     = is_free_q;
	assign found_index = found_q;
	assign status      = status_q;

`ifndef SYNTH
	// input and result are never open at once
	assert_in_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a result is pending");

	// a taken result frees the block for the next item
	assert_resp_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("block not idle after result transfer");

	// the walk never leaves the store
	assert_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (mem_wr_addr <= LAST_ADDR))
		else $error("bitmap write beyond the store");

	// is_free only reported by a test
	assert_free_on_test: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_free) |-> (act_q == bma_pkg::ACT_TEST_BIT))
		else $error("is_free set for an action other than test");

	// a search hit ends the walk with a good status
	assert_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bma_pkg::ST_EVAL && ev.hit) |=> (out_valid && !status))
		else $error("search hit did not produce a result");
`endif

endmodule

>>> src/bma_mem.sv
// ----------------------------------------------------------------------------
// bma_mem
// bitmap byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module bma_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [bma_pkg::BYTE_BITS-1:0]  rd_data,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [bma_pkg::BYTE_BITS-1:0]  wr_data
);

	logic [bma_pkg::BYTE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/bma_eval.sv
// ----------------------------------------------------------------------------
// bma_eval
// byte update logic: bit window mask, modify value, search hit
// ----------------------------------------------------------------------------
module bma_eval #(
	parameter int POS_W = 17
) (
	input  bma_pkg::action_t               action,
	input  logic [bma_pkg::BYTE_BITS-1:0]  rd_data,
	input  logic [POS_W-1:0]               base,
	input  logic [POS_W-1:0]               lo,
	input  logic [POS_W-1:0]               hi,
	output bma_pkg::eval_t                 res
);

	logic [bma_pkg::BYTE_BITS-1:0] mask;
	logic [bma_pkg::BYTE_BITS-1:0] cand;
	logic [POS_W-1:0]              next_base;
	logic [2:0]                    first_bit;

	// bits of this byte that lie in [lo, hi)
	always_comb begin
		logic [POS_W-1:0] pos;
		for (int j = 0; j < bma_pkg::BYTE_BITS; j++) begin
			pos     = base + POS_W'(j);
			mask[j] = (pos >= lo) && (pos < hi);
		end
	end

	assign cand      = ~rd_data & mask;
	assign next_base = base + POS_W'(bma_pkg::BYTE_BITS);

	// lowest free bit in the window
	always_comb begin
		first_bit = 3'd0;
		for (int j = bma_pkg::BYTE_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				first_bit = 3'(j);
			end
		end
	end

	always_comb begin
		res          = '0;
		res.new_byte = rd_data;
		res.any_free = |cand;
		res.more     = next_base < hi;
		unique case (action)
			bma_pkg::ACT_FREE_BIT,
			bma_pkg::ACT_FREE_RUN: begin
				res.new_byte = rd_data & ~mask;
				res.wr_en    = 1'b1;
			end
			bma_pkg::ACT_SET_BIT: begin
				res.new_byte = rd_data | mask;
				res.wr_en    = 1'b1;
			end
			bma_pkg::ACT_TEST_BIT: begin
				res.wr_en = 1'b0;
			end
			bma_pkg::ACT_FIND_BYTE: begin
				if (mask[0] && (rd_data == '0)) begin
					res.hit      = 1'b1;
					res.hit_bit  = 3'd0;
					res.new_byte = bma_pkg::BYTE_FIRST;
					res.wr_en    = 1'b1;
				end
			end
			bma_pkg::ACT_FIND_BIT: begin
				if (|cand) begin
					res.hit      = 1'b1;
					res.hit_bit  = first_bit;
					res.new_byte = rd_data | (8'(1) << first_bit);
					res.wr_en    = 1'b1;
				end
			end
			default: begin
				res.wr_en = 1'b0;
			end
		endcase
	end

endmodule

>>> test/tb_bitmap_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_allocator_core
// self-checking bench for the bitmap allocator core
// ----------------------------------------------------------------------------
// A short directed opening covers the corner cases: field extremes, every
// action, unknown action codes, run clipping at the bitmap end, searches that
// start at or past the limit, limits that fall inside a byte, a zero limit and
// a limit above the bitmap size. Randomized phases then work small windows of
// the bitmap under different limits, so that searches walk into filled areas
// and run into the limit. A shadow bitmap predicts every result bit for bit.
// ----------------------------------------------------------------------------
module tb_bitmap_allocator_core;

	localparam int NUM_BITS      = 32768;
	localparam int MAP_BYTES     = (NUM_BITS + 7) / 8;
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYC     = 8;
	// worst gap between transfers: clearing pass or a full-map walk plus a long stall
	localparam int WATCHDOG      = 60000;
	localparam int LONG_HOLD_AT  = 60;
	localparam int LONG_HOLD_CYC = 300;
	localparam int TAIL_CYC      = 40;

	localparam logic [bma_pkg::ADDR_W-1:0] LIMIT_ADDR =
		bma_pkg::ADDR_W'(4 * bma_pkg::REG_BIT_LIMIT);
	// action codes the block does not know
	localparam logic [bma_pkg::ACTION_W-1:0] ACT_SPARE_A    = 3'd6;
	localparam logic [bma_pkg::ACTION_W-1:0] ACT_SPARE_B    = 3'd7;
	localparam logic [bma_pkg::LIMIT_W-1:0]  LIMIT_ALL_ONES = '1;
	localparam int                           COUNT_MAX      = NUM_BITS;

	// how a random phase picks its bit limit
	typedef enum {
		LIM_FULL,
		LIM_WINDOW,
		LIM_RANDOM,
		LIM_OVER,
		LIM_TINY
	} limit_plan_t;

	typedef struct packed {
		logic [bma_pkg::ACTION_W-1:0] act;
		logic [bma_pkg::INDEX_W-1:0]  idx;
		logic [bma_pkg::COUNT_W-1:0]  cnt;
	} alloc_req_t;

	typedef struct packed {
		logic                        free_flag;
		logic [bma_pkg::FOUND_W-1:0] found;
		logic                        miss;
	} alloc_resp_t;

	// dut connections, all known from time zero
	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           psel        = 1'b0;
	logic                           penable     = 1'b0;
	logic                           pwrite      = 1'b0;
	logic [bma_pkg::ADDR_W-1:0]     paddr       = '0;
	logic [bma_pkg::APB_DATA_W-1:0] pwdata      = '0;
	logic [bma_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [bma_pkg::ACTION_W-1:0]   action      = '0;
	logic [bma_pkg::INDEX_W-1:0]    bit_pos     = '0;
	logic [bma_pkg::COUNT_W-1:0]    bit_count   = '0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic                           is_free;
	logic [bma_pkg::FOUND_W-1:0]    found_index;
	logic                           status;

	// shadow of the block state
	logic [7:0]                  bitmap_shadow [MAP_BYTES];
	logic [bma_pkg::LIMIT_W-1:0] limit_shadow;

	// requests waiting for the driver, and results still owed by the block
	alloc_req_t  req_backlog [$];
	alloc_resp_t resp_due    [$];
	alloc_req_t  req_live;

	bit quiet          = 1'b0;
	bit long_hold_done = 1'b0;
	int send_gap       = 0;
	int hold_left      = 0;
	int stall_cyc      = 0;
	int n_sent         = 0;
	int n_checked      = 0;
	int n_errors       = 0;
	int n_misses       = 0;
	int n_limits       = 0;

	bitmap_allocator_core #(
		.NUM_BITS(NUM_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.bit_pos(bit_pos),
		.bit_count(bit_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_free(is_free),
		.found_index(found_index),
		.status(status)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// shadow bitmap access; bits past the map end read as taken, writes drop
	// ------------------------------------------------------------------------
	function automatic logic shadow_bit(int b);
		if (b >= NUM_BITS) begin
			return 1'b1;
		end
		return bitmap_shadow[b / 8][b % 8];
	endfunction

	function automatic void shadow_put(int b, logic v);
		if (b < NUM_BITS) begin
			bitmap_shadow[b / 8][b % 8] = v;
		end
	endfunction

	// ------------------------------------------------------------------------
	// work out the result of one request and update the shadow bitmap
	// ------------------------------------------------------------------------
	function automatic alloc_resp_t apply_action(alloc_req_t r);
		alloc_resp_t rsp;
		int          lim;
		int          b;
		int          stop;
		rsp = '0;
		// a limit above the map size acts as the map size
		lim = (int'(limit_shadow) > NUM_BITS) ? NUM_BITS : int'(limit_shadow);
		case (r.act)
			bma_pkg::ACT_FREE_BIT: begin
				shadow_put(int'(r.idx), 1'b0);
			end
			bma_pkg::ACT_FREE_RUN: begin
				// run is clipped at the end of the map
				stop = int'(r.idx) + int'(r.cnt);
				if (stop > NUM_BITS) begin
					stop = NUM_BITS;
				end
				for (b = int'(r.idx); b < stop; b++) begin
					shadow_put(b, 1'b0);
				end
			end
			bma_pkg::ACT_SET_BIT: begin
				shadow_put(int'(r.idx), 1'b1);
			end
			bma_pkg::ACT_TEST_BIT: begin
				rsp.free_flag = !shadow_bit(int'(r.idx));
			end
			bma_pkg::ACT_FIND_BYTE: begin
				// start rounded up to a byte, byte taken only if its first bit is below the limit
				b = (int'(r.idx) + 7) & ~7;
				rsp.miss = 1'b1;
				while (rsp.miss && b < lim) begin
					if (bitmap_shadow[b / 8] == '0) begin
						bitmap_shadow[b / 8] = bma_pkg::BYTE_FIRST;
						rsp.found = b[bma_pkg::FOUND_W-1:0];
						rsp.miss = 1'b0;
					end else begin
						b += 8;
					end
				end
			end
			bma_pkg::ACT_FIND_BIT: begin
				// bit by bit, never at or past the limit, even inside its byte
				b = int'(r.idx);
				rsp.miss = 1'b1;
				while (rsp.miss && b < lim) begin
					if (!shadow_bit(b)) begin
						shadow_put(b, 1'b1);
						rsp.found = b[bma_pkg::FOUND_W-1:0];
						rsp.miss = 1'b0;
					end else begin
						b++;
					end
				end
			end
			default: begin
				// unknown code: state untouched, result all zero
			end
		endcase
		return rsp;
	endfunction

	// ------------------------------------------------------------------------
	// random request shaped around a working window of the bitmap
	// ------------------------------------------------------------------------
	function automatic alloc_req_t make_req(int lo, int span, bit fill_heavy);
		alloc_req_t r;
		int         pick;
		int         cut [6];
		int         roll;
		if (fill_heavy) begin
			cut = '{2, 55, 70, 78, 84, 96};
		end else begin
			cut = '{5, 30, 45, 60, 70, 90};
		end
		pick = $urandom_range(0, 99);
		if (pick < cut[0]) begin
			r.act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
		end else if (pick < cut[1]) begin
			r.act = bma_pkg::ACT_FIND_BIT;
		end else if (pick < cut[2]) begin
			r.act = bma_pkg::ACT_FIND_BYTE;
		end else if (pick < cut[3]) begin
			r.act = bma_pkg::ACT_SET_BIT;
		end else if (pick < cut[4]) begin
			r.act = bma_pkg::ACT_FREE_BIT;
		end else if (pick < cut[5]) begin
			r.act = bma_pkg::ACT_TEST_BIT;
		end else begin
			r.act = bma_pkg::ACT_FREE_RUN;
		end
		// mostly inside the window, now and then anywhere in the map
		if ($urandom_range(0, 99) < 85) begin
			r.idx = bma_pkg::INDEX_W'(lo + $urandom_range(0, span - 1));
		end else begin
			r.idx = bma_pkg::INDEX_W'($urandom_range(0, NUM_BITS - 1));
		end
		if (r.act == bma_pkg::ACT_FREE_RUN) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				r.cnt = bma_pkg::COUNT_W'($urandom_range(4096, COUNT_MAX));
			end else if (roll < 70) begin
				r.cnt = bma_pkg::COUNT_W'($urandom_range(0, span));
			end else begin
				r.cnt = bma_pkg::COUNT_W'($urandom_range(0, 16));
			end
		end else begin
			// count is ignored here, so any legal value
			r.cnt = bma_pkg::COUNT_W'($urandom_range(0, COUNT_MAX));
		end
		return r;
	endfunction

	task automatic send(logic [bma_pkg::ACTION_W-1:0] act, int idx, int cnt);
		alloc_req_t r;
		r.act = act;
		r.idx = idx[bma_pkg::INDEX_W-1:0];
		r.cnt = cnt[bma_pkg::COUNT_W-1:0];
		req_backlog.push_back(r);
	endtask

	// sender holds back until every owed result has come out
	task automatic drain();
		@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || resp_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_limit(logic [bma_pkg::LIMIT_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {{(bma_pkg::APB_DATA_W - bma_pkg::LIMIT_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		limit_shadow = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_limits++;
	endtask

	// one random phase: wait for idle, set the limit, queue the requests
	task automatic run_phase(limit_plan_t plan, bit fill_heavy, int n_items);
		int span;
		int lo;
		int lim;
		span = $urandom_range(64, 512);
		lo   = $urandom_range(0, (NUM_BITS - span) / 8) * 8;
		case (plan)
			LIM_FULL:   lim = NUM_BITS;
			// limit 1 to 7 bits short of the window end
			LIM_WINDOW: lim = lo + span - $urandom_range(1, 7);
			LIM_RANDOM: lim = $urandom_range(0, NUM_BITS);
			LIM_OVER:   lim = int'(LIMIT_ALL_ONES);
			default: begin
				lo  = 0;
				lim = $urandom_range(1, 15);
			end
		endcase
		drain();
		write_limit(lim[bma_pkg::LIMIT_W-1:0]);
		for (int k = 0; k < n_items; k++) begin
			req_backlog.push_back(make_req(lo, span, fill_heavy));
		end
	endtask

	// ------------------------------------------------------------------------
	// input driver: fed from the backlog, random gaps after a transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_side
		alloc_req_t nxt_req;
		logic       nxt_valid;
		nxt_valid = in_valid;
		nxt_req   = req_live;
		if (in_valid && in_ready) begin
			// predicted in transfer order, the block works items one at a time
			resp_due.push_back(apply_action(req_live));
			if (resp_due[$].miss) begin
				n_misses++;
			end
			n_sent++;
			nxt_valid = 1'b0;
			if (!quiet && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(1, 8);
			end
		end
		if (!nxt_valid && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (req_backlog.size() != 0) begin
				nxt_req   = req_backlog.pop_front();
				nxt_valid = 1'b1;
			end
		end
		req_live  = nxt_req;
		in_valid  <= nxt_valid;
		action    <= nxt_req.act;
		bit_pos   <= nxt_req.idx;
		bit_count <= nxt_req.cnt;
	end

	// ------------------------------------------------------------------------
	// result monitor and output back-pressure
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_side
		alloc_resp_t want;
		logic        nxt_ready;
		if (out_valid && out_ready) begin
			n_checked++;
			if (resp_due.size() == 0) begin
				$error("result transfer with nothing outstanding, found_index %0d", found_index);
				n_errors++;
			end else begin
				want = resp_due.pop_front();
				if (is_free !== want.free_flag) begin
					$error("is_free: expected %0d, actual %0d", want.free_flag, is_free);
					n_errors++;
				end
				if (found_index !== want.found) begin
					$error("found_index: expected %0d, actual %0d", want.found, found_index);
					n_errors++;
				end
				if (status !== want.miss) begin
					$error("status: expected %0d, actual %0d", want.miss, status);
					n_errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			nxt_ready = 1'b0;
		end else if (!long_hold_done && n_checked >= LONG_HOLD_AT) begin
			// one long stall so the block backs up into its input
			long_hold_done = 1'b1;
			hold_left      = LONG_HOLD_CYC - 1;
			nxt_ready      = 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 7);
			nxt_ready = 1'b0;
		end else begin
			nxt_ready = arst_n;
		end
		out_ready <= nxt_ready;
	end

	// ------------------------------------------------------------------------
	// watchdog: cycles without any transfer while work is outstanding
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (req_backlog.size() == 0 && !in_valid && resp_due.size() == 0)) begin
			stall_cyc = 0;
		end else begin
			stall_cyc++;
		end
		if (stall_cyc >= WATCHDOG) begin
			$display("timeout after %0d cycles without a transfer", stall_cyc);
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		for (int i = 0; i < MAP_BYTES; i++) begin
			bitmap_shadow[i] = '0;
		end
		limit_shadow = bma_pkg::LIMIT_RESET;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		// reset limit, single bits, searches, clipping, unknown codes
		send(bma_pkg::ACT_TEST_BIT, 0, 0);
		send(bma_pkg::ACT_SET_BIT, 0, 0);
		send(bma_pkg::ACT_TEST_BIT, 0, 0);
		send(bma_pkg::ACT_SET_BIT, NUM_BITS - 1, 0);
		send(bma_pkg::ACT_TEST_BIT, NUM_BITS - 1, 0);
		send(bma_pkg::ACT_FIND_BIT, 0, 0);
		send(bma_pkg::ACT_FIND_BYTE, 1, 0);
		// last bit taken, search has nowhere to go
		send(bma_pkg::ACT_FIND_BIT, NUM_BITS - 1, 0);
		// run past the map end gets clipped
		send(bma_pkg::ACT_FREE_RUN, NUM_BITS - 8, COUNT_MAX);
		send(bma_pkg::ACT_TEST_BIT, NUM_BITS - 1, 0);
		send(bma_pkg::ACT_FREE_BIT, 0, 0);
		send(ACT_SPARE_A, NUM_BITS - 1, COUNT_MAX);
		send(ACT_SPARE_B, 0, 0);
		// whole map freed in one run
		send(bma_pkg::ACT_FREE_RUN, 0, COUNT_MAX);
		drain();

		// limit inside a byte: bits 8..12 usable, 12 already taken
		write_limit(bma_pkg::LIMIT_W'(13));
		send(bma_pkg::ACT_SET_BIT, 12, 0);
		send(bma_pkg::ACT_FIND_BIT, 8, 0);
		send(bma_pkg::ACT_FIND_BIT, 9, 0);
		send(bma_pkg::ACT_FIND_BIT, 9, 0);
		send(bma_pkg::ACT_FIND_BIT, 9, 0);
		send(bma_pkg::ACT_FIND_BIT, 9, 0);
		// start at the limit
		send(bma_pkg::ACT_FIND_BIT, 13, 0);
		send(bma_pkg::ACT_FIND_BYTE, 0, 0);
		send(bma_pkg::ACT_FIND_BYTE, 1, 0);
		drain();

		write_limit('0);
		send(bma_pkg::ACT_FIND_BIT, 0, 0);
		send(bma_pkg::ACT_FIND_BYTE, 0, 0);
		drain();

		// limit above the map size
		write_limit(LIMIT_ALL_ONES);
		send(bma_pkg::ACT_FIND_BYTE, NUM_BITS - 7, 0);
		send(bma_pkg::ACT_FIND_BYTE, NUM_BITS - 15, 0);
		send(bma_pkg::ACT_FIND_BIT, NUM_BITS - 8, 0);

		// random phases, each waits for idle before its limit write
		run_phase(LIM_FULL, 1'b0, 75);
		run_phase(LIM_WINDOW, 1'b1, 75);
		run_phase(LIM_RANDOM, 1'b0, 70);
		run_phase(LIM_OVER, 1'b1, 70);
		run_phase(LIM_TINY, 1'b0, 50);
		drain();
		// closing stretch at full rate on both sides
		quiet = 1'b1;
		run_phase(LIM_FULL, 1'b0, 110);
		drain();
		repeat (TAIL_CYC) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d searches found no space",
			n_sent, n_checked, n_misses);
		$display("%0d bit limit settings, with one long output stall and idle pauses",
			n_limits);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
